// ----- hw/rtl/dpws_pkg.sv -----
// Shared types and constants for the dark pixel window spread block.
// No dependencies; imported by the top level, the output queue and the checker.

package dpws_pkg;

    // Sizing defaults and fixed window geometry
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int EDGE_MARGIN    = 3;
    localparam int WINDOW_SIZE    = 5;
    localparam int HIST_ROWS      = WINDOW_SIZE - 1;
    localparam int MIN_DIM        = 8;
    localparam int CFG_W          = 11;
    localparam int RST_WIDTH      = 640;
    localparam int RST_HEIGHT     = 480;
    localparam int OUTQ_DEPTH     = 3;

    localparam logic [7:0] WHITE_LEVEL = 8'd255;
    localparam logic [7:0] DARK_LEVEL  = 8'd0;

    // Register indexes of the configuration port
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx REG_FRAME_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_FRAME_HEIGHT = 2'd1;

    // Channel payloads
    typedef struct packed {
        logic [7:0] pixel_value;
        logic       is_padding;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       last_of_frame;
    } t_out_item;

endpackage

// ----- hw/rtl/dpws_out_q.sv -----
// Small output queue that decouples the result stage from the receiver.
// Depends on dpws_pkg for the result payload type.

module dpws_out_q #(
    parameter int DEPTH = dpws_pkg::OUTQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  dpws_pkg::t_out_item        i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output dpws_pkg::t_out_item        o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import dpws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    t_out_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage: no reset, entries are read only after a push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/dark_pixel_window_spread.sv -----
// Top level of the dark pixel window spread (5x5 dilation of dark marks).
// Depends on dpws_pkg and instantiates dpws_out_q.
//
// Usage: pixels enter in raster order on the input channel (valid/stall),
// one per clock. A pixel equal to zero at least three pixels inside every
// frame edge is a dark mark; output pixel (r,c) is 0 when a mark lies in
// rows r-1..r+3 and columns c-1..c+3, else 255. Output position p belongs
// to input position p+3*width+3, so the first 3*width+3 inputs of a frame
// give no result and the host appends that many padding items per frame.
// The last result of a frame carries last_of_frame.
// Throughput is one item per cycle while the input is not stalled: a line
// store of width entries, read and written back once per item on its
// registered read port, holds four rows of horizontal window ORs. A result
// passes the result stage register and then the output queue. A three-entry
// output queue absorbs receiver stalls; the input stalls once the queue and
// the result stage together hold three items. Reset restores width 640 and
// height 480 (clamped to the maximums) and the frame start; the line store
// needs no clearing. A width or height write restarts the frame.

module dark_pixel_window_spread #(
    parameter int MAX_WIDTH  = dpws_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dpws_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  dpws_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output dpws_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_we,
    input  dpws_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [dpws_pkg::CFG_W-1:0]   i_cfg_data
);
    import dpws_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WDIM_W = $clog2(MAX_WIDTH+1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT+1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT+EDGE_MARGIN+1);
    localparam int CNT_W  = $clog2(OUTQ_DEPTH+1);
    localparam int RST_W_CLAMP = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_H_CLAMP = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

    // Configuration and stream position
    logic              r_run;
    logic [WDIM_W-1:0] r_width, n_cfg_w;
    logic [HDIM_W-1:0] r_height, n_cfg_h;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [WINDOW_SIZE-2:0] r_hist;

    // Result stage
    logic                 r_s1_valid;
    logic                 r_s1_emit;
    logic                 r_s1_last;
    logic                 r_s1_top;
    logic                 r_s1_h0;
    logic [COL_W-1:0]     r_s1_col;
    logic [HIST_ROWS-1:0] r_rd;
    logic [HIST_ROWS-1:0] line_mem [MAX_WIDTH];

    logic             in_xfer;
    logic             cfg_hit;
    logic             frame_start;
    logic             col_in, row_in, mark, h0;
    logic             warm, top, last, col_wrap;
    logic             s1_dark;
    t_out_item        s1_item;
    logic [CNT_W-1:0] q_count;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign cfg_hit = i_cfg_we && ((i_cfg_idx == REG_FRAME_WIDTH) ||
                                  (i_cfg_idx == REG_FRAME_HEIGHT));

    // Accept once out of reset while the queue plus the result stage has room
    assign o_in_stall = !r_run ||
        (((CNT_W+1)'(q_count) + (CNT_W+1)'(r_s1_valid)) >= (CNT_W+1)'(OUTQ_DEPTH));

    // Register writes are saturated to the legal range
    always_comb begin
        if (32'(i_cfg_data) < MIN_DIM) begin
            n_cfg_w = WDIM_W'(MIN_DIM);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            n_cfg_w = WDIM_W'(MAX_WIDTH);
        end else begin
            n_cfg_w = WDIM_W'(i_cfg_data);
        end
        if (32'(i_cfg_data) < MIN_DIM) begin
            n_cfg_h = HDIM_W'(MIN_DIM);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            n_cfg_h = HDIM_W'(MAX_HEIGHT);
        end else begin
            n_cfg_h = HDIM_W'(i_cfg_data);
        end
    end

    // Position decode: mark region, warm-up, top window row, frame end
    always_comb begin
        frame_start = (r_row == '0) && (r_col == '0);
        col_in = (r_col >= COL_W'(EDGE_MARGIN)) &&
                 (((COL_W+1)'(r_col) + (COL_W+1)'(EDGE_MARGIN)) < (COL_W+1)'(r_width));
        row_in = (r_row >= ROW_W'(EDGE_MARGIN)) &&
                 (((ROW_W+1)'(r_row) + (ROW_W+1)'(EDGE_MARGIN)) < (ROW_W+1)'(r_height));
        mark = !i_in_item.is_padding && (i_in_item.pixel_value == DARK_LEVEL) &&
               row_in && col_in;
        // horizontal OR of the newest five marks; earlier frames do not count
        h0 = mark || (!frame_start && (|r_hist));
        warm = (r_row < ROW_W'(EDGE_MARGIN)) ||
               ((r_row == ROW_W'(EDGE_MARGIN)) && (r_col < COL_W'(EDGE_MARGIN)));
        // window row above the frame for the first output row
        top = (r_row < ROW_W'(EDGE_MARGIN+1)) ||
              ((r_row == ROW_W'(EDGE_MARGIN+1)) && (r_col < COL_W'(EDGE_MARGIN)));
        last = (r_row == (ROW_W'(r_height) + ROW_W'(EDGE_MARGIN))) &&
               (r_col == COL_W'(EDGE_MARGIN-1));
        col_wrap = (((COL_W+1)'(r_col) + (COL_W+1)'(1)) == (COL_W+1)'(r_width));
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_wrap) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_width    <= WDIM_W'(RST_W_CLAMP);
            r_height   <= HDIM_W'(RST_H_CLAMP);
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_run      <= 1'b1;
            r_s1_valid <= in_xfer;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  r_width  <= n_cfg_w;
                    REG_FRAME_HEIGHT: r_height <= n_cfg_h;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_xfer) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Stage payload and horizontal mark history
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_hist    <= frame_start ? {{(WINDOW_SIZE-2){1'b0}}, mark}
                                     : {r_hist[WINDOW_SIZE-3:0], mark};
            r_s1_emit <= !warm;
            r_s1_last <= last;
            r_s1_top  <= top;
            r_s1_h0   <= h0;
            r_s1_col  <= r_col;
        end
    end

    // Line store: read at accept, write back from the result stage.
    // Consecutive items of a frame hit different columns, so read and write never meet.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd <= line_mem[r_col];
        end
        if (r_s1_valid) begin
            line_mem[r_s1_col] <= {r_rd[HIST_ROWS-2:0], r_s1_h0};
        end
    end

    // Vertical OR over the five window rows
    always_comb begin
        s1_dark = r_s1_h0 || (|r_rd[HIST_ROWS-2:0]) ||
                  (r_rd[HIST_ROWS-1] && !r_s1_top);
        s1_item.out_pixel     = s1_dark ? DARK_LEVEL : WHITE_LEVEL;
        s1_item.last_of_frame = r_s1_last;
    end

    dpws_out_q #(
        .DEPTH (OUTQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid && r_s1_emit),
        .i_data  (s1_item),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_item),
        .o_count (q_count)
    );

endmodule

// ----- hw/rtl/dpws_checker.sv -----
// Port-level assertions for dark_pixel_window_spread, bound to the top level.
// Depends on dpws_pkg for payload types and pixel levels.

module dpws_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input dpws_pkg::t_out_item        o_out_item
);
    import dpws_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

    // Nothing is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present right after reset");

    // A result first appears only after an input transfer has passed the result stage and the output queue
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without a matching input transfer");

    // Results are binary levels
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.out_pixel == DARK_LEVEL) ||
                         (o_out_item.out_pixel == WHITE_LEVEL)))
        else $error("result pixel is neither dark nor white");

endmodule

bind dark_pixel_window_spread dpws_checker u_dpws_checker (.*);

// ----- verif/tb_dark_pixel_window_spread.sv -----
// Self-checking testbench for dark_pixel_window_spread: drives raster frames with
// random idling and back-pressure, predicts every result pixel and checks it in order.
// Depends on dpws_pkg and the dark_pixel_window_spread RTL.

module tb_dark_pixel_window_spread;
    import dpws_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    // mark ring: four window rows plus the window width
    localparam int RING_LEN      = HIST_ROWS * MAX_W + WINDOW_SIZE;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 950;
    localparam int REPORT_CAP    = 200;

    // indexes that decode to no register
    localparam t_cfg_idx REG_UNUSED_2 = 2'd2;
    localparam t_cfg_idx REG_UNUSED_3 = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    // predicted block state
    bit                  dark_marks [RING_LEN];
    int                  frame_pos;
    int                  cur_width;
    int                  cur_height;
    t_out_item           expected_pixels [$];

    int                  error_count;
    int                  pixels_sent;
    bit                  steady;
    int                  hold_asks;
    int                  hold_seen;
    int                  hold_left;

    dark_pixel_window_spread i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 10-unit clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void apply_reg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] d);
        case (idx)
            REG_FRAME_WIDTH: begin
                cur_width = clamp_dim(int'(d), MAX_W);
                frame_pos = 0;
            end
            REG_FRAME_HEIGHT: begin
                cur_height = clamp_dim(int'(d), MAX_H);
                frame_pos = 0;
            end
            default: ;
        endcase
    endfunction

    // Returns 1 when the transfer yields a result pixel, written to res.
    function automatic bit spread_predict(input t_in_item it, output t_out_item res);
        int w, h, q, lag, row, col, p, r, c, rr, cc;
        bit mark, dark, last;
        w   = cur_width;
        h   = cur_height;
        q   = frame_pos;
        lag = EDGE_MARGIN * w + EDGE_MARGIN;
        row = q / w;
        col = q % w;
        res = '0;
        // only zeros well inside the frame count; flush positions fall out by row
        mark = !it.is_padding && (it.pixel_value == DARK_LEVEL) &&
               row >= EDGE_MARGIN && row + EDGE_MARGIN < h &&
               col >= EDGE_MARGIN && col + EDGE_MARGIN < w;
        dark_marks[q % RING_LEN] = mark;
        if (q < lag) begin
            frame_pos = q + 1;
            return 1'b0;
        end
        p    = q - lag;
        r    = p / w;
        c    = p % w;
        dark = 1'b0;
        for (int di = 0; di < WINDOW_SIZE; di++) begin
            rr = r - 1 + di;
            if (rr < 0 || rr >= h) continue;
            for (int dj = 0; dj < WINDOW_SIZE; dj++) begin
                cc = c - 1 + dj;
                if (cc < 0 || cc >= w) continue;
                if (dark_marks[(rr * w + cc) % RING_LEN]) dark = 1'b1;
            end
        end
        last              = (p + 1 >= w * h);
        res.out_pixel     = dark ? DARK_LEVEL : WHITE_LEVEL;
        res.last_of_frame = last;
        frame_pos         = last ? 0 : q + 1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_item pick_pixel(input int dark_pct);
        t_in_item it;
        it.is_padding = ($urandom_range(0, 99) < 3);
        if ($urandom_range(0, 99) < dark_pct) it.pixel_value = DARK_LEVEL;
        else it.pixel_value = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // flush item, now and then an unflagged zero as noise
    function automatic t_in_item pick_flush();
        t_in_item it;
        it.pixel_value = 8'($urandom_range(0, 255));
        it.is_padding  = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
            it.is_padding  = 1'b0;
            it.pixel_value = DARK_LEVEL;
        end
        return it;
    endfunction

    // One input transfer, with a random gap ahead of it unless steady
    task automatic send_pixel(input t_in_item it);
        bit took;
        t_out_item res;
        while (!steady && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        pixels_sent++;
        if (spread_predict(it, res)) expected_pixels.push_back(res);
    endtask

    task automatic send_flush(input int n);
        for (int i = 0; i < n; i++) send_pixel(pick_flush());
    endtask

    task automatic send_frame(input int dark_pct, input int tail_len, input int pixel_count);
        for (int i = 0; i < pixel_count; i++) send_pixel(pick_pixel(dark_pct));
        send_flush(tail_len);
    endtask

    // Sender pauses until every predicted result has been seen
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Drained, then a settle wait for warm-up items still in the pipe
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg_write(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(input int w, input int h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frame with hand-placed pixels around the margin and flush noise
    task automatic test_directed_frame();
        t_in_item it;
        set_size(MIN_DIM, MIN_DIM);
        for (int r = 0; r < MIN_DIM; r++) begin
            for (int c = 0; c < MIN_DIM; c++) begin
                it.is_padding  = 1'b0;
                it.pixel_value = WHITE_LEVEL;
                if (r == 3 && c == 3) it.pixel_value = DARK_LEVEL;      // inner corner mark
                if (r == 3 && c == 4) it.pixel_value = 8'd1;
                if (r == 4 && c == 3) it.pixel_value = 8'd128;
                if (r == 4 && c == 4) begin                              // flagged zero: no mark
                    it.pixel_value = DARK_LEVEL;
                    it.is_padding  = 1'b1;
                end
                // zeros just outside the margin and at the frame corners
                if ((r == 2 && c == 3) || (r == 3 && c == 2) || (r == 5 && c == 4) ||
                    (r == 4 && c == 5) || (r == 0 && c == 0) || (r == 7 && c == 7))
                    it.pixel_value = DARK_LEVEL;
                send_pixel(it);
            end
        end
        for (int i = 0; i < EDGE_MARGIN * MIN_DIM + EDGE_MARGIN; i++) begin
            it.is_padding  = (i >= 3);
            it.pixel_value = (i < 3 || i % 2 == 0) ? DARK_LEVEL : WHITE_LEVEL;
            send_pixel(it);
        end
        wait_idle();
    endtask

    // Out-of-range and boundary register values, unknown indexes
    task automatic test_size_extremes();
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, CFG_W'(MAX_H));
        write_reg(REG_FRAME_WIDTH, CFG_W'(7));
        write_reg(REG_FRAME_HEIGHT, '1);
        // top rows of a tall narrow frame
        send_frame(20, 0, 24 * cur_width);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(MAX_W + 1));
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_UNUSED_2, '1);
        write_reg(REG_FRAME_HEIGHT, '0);
        write_reg(REG_UNUSED_3, CFG_W'(11'h555));
        // widest rows: warm-up only
        send_frame(2, 0, 60);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, '0);
        send_frame(20, EDGE_MARGIN * cur_width + EDGE_MARGIN, cur_width * cur_height);
        wait_idle();
    endtask

    // Unknown index keeps the frame going; a real write restarts it
    task automatic test_restart();
        set_size(12, 10);
        send_frame(30, 0, 70);
        wait_idle();
        write_reg(REG_UNUSED_3, CFG_W'($urandom));
        send_frame(30, 0, 20);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(12));
        send_frame(30, EDGE_MARGIN * cur_width + EDGE_MARGIN, cur_width * cur_height);
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        set_size(10, 9);
        hold_asks++;
        send_frame(40, EDGE_MARGIN * cur_width + EDGE_MARGIN, cur_width * cur_height);
        wait_idle();
    endtask

    // Sender stops mid-frame until every result is out, then finishes the frame
    task automatic test_drain_pause();
        int total;
        set_size(9, 11);
        total = cur_width * cur_height;
        for (int i = 0; i < total; i++) begin
            if (i == total / 2) wait_drained();
            send_pixel(pick_pixel(25));
        end
        send_flush(EDGE_MARGIN * cur_width + EDGE_MARGIN);
        wait_idle();
    endtask

    // Mostly well-formed frames of random size and density, some broken ones
    task automatic test_random_frames();
        int start_count, frame_no, dark, kind, lag, full;
        start_count = pixels_sent;
        frame_no    = 0;
        while (pixels_sent - start_count < RANDOM_ITEMS) begin
            frame_no++;
            steady = (frame_no % 5 == 3);
            if ($urandom_range(0, 99) < 60) begin
                wait_idle();
                if ($urandom_range(0, 9) == 0) write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, 7)));
                else write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(8, 20)));
                if ($urandom_range(0, 9) == 0) write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 7)));
                else write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(8, 14)));
                if ($urandom_range(0, 9) == 0)
                    write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_W'($urandom));
            end
            case ($urandom_range(0, 3))
                0: dark = 0;
                1: dark = 5;
                2: dark = 30;
                default: dark = 90;
            endcase
            lag  = EDGE_MARGIN * cur_width + EDGE_MARGIN;
            full = cur_width * cur_height;
            kind = $urandom_range(0, 99);
            if (kind < 80) send_frame(dark, lag, full);
            else if (kind < 88) send_frame(dark, $urandom_range(0, lag - 1), full);   // short tail
            else if (kind < 94) send_frame(dark, lag + $urandom_range(1, 20), full); // long tail
            else send_frame(dark, 0, $urandom_range(1, full - 1));                   // cut frame
        end
        steady = 1'b0;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(0, 99) < 20);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: inputs move only at rising edges, so the falling edge
    // sees exactly what the next rising edge transfers
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_CAP)
                    $error("unexpected result transfer: out_pixel %0d last_of_frame %0d",
                           o_out_item.out_pixel, o_out_item.last_of_frame);
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_item.out_pixel !== want.out_pixel) begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $error("out_pixel: expected %0d, actual %0d",
                               want.out_pixel, o_out_item.out_pixel);
                end
                if (o_out_item.last_of_frame !== want.last_of_frame) begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $error("last_of_frame: expected %0d, actual %0d",
                               want.last_of_frame, o_out_item.last_of_frame);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_FRAME_WIDTH;
        i_cfg_data  = '0;
        error_count = 0;
        pixels_sent = 0;
        steady      = 1'b0;
        hold_asks   = 0;
        hold_seen   = 0;
        hold_left   = 0;
        // reset state of the prediction
        foreach (dark_marks[i]) dark_marks[i] = 1'b0;
        frame_pos  = 0;
        cur_width  = clamp_dim(RST_WIDTH, MAX_W);
        cur_height = clamp_dim(RST_HEIGHT, MAX_H);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frame();
        test_size_extremes();
        test_restart();
        test_backpressure();
        test_drain_pause();
        test_random_frames();

        if (expected_pixels.size() != 0) begin
            error_count++;
            $error("%0d expected results never arrived", expected_pixels.size());
        end
        if (error_count == 0) begin
            $display("[dark_pixel_window_spread] OK");
        end else begin
            $display("[dark_pixel_window_spread] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6000000;
        $display("[dark_pixel_window_spread] ERROR");
        $finish;
    end

endmodule
